### hdl/dltq_pkg.sv
// Shared types and constants for the delta-list timer queue.
`timescale 1ns / 1ps
`default_nettype none

package dltq_pkg;

  localparam int unsigned DELTA_W     = 31;
  localparam int unsigned SEQ_W       = 32;
  localparam int unsigned PORT_W      = 16;
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned MAX_RESULTS = 16;
  localparam int unsigned NRES_W      = $clog2(MAX_RESULTS + 1);

  // Input word selector (tuser).
  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_INSERT = 1'b1;

  // Result kinds.
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 2'd0;
  localparam logic [KIND_W-1:0] KIND_FULL     = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EXPIRED  = 2'd2;

  // One pending timer held by a cell.
  typedef struct packed {
    logic               vld;
    logic [DELTA_W-1:0] delta;
    logic [SEQ_W-1:0]   seq;
    logic [PORT_W-1:0]  port;
  } dltq_entry_t;

  // Item travelling down the chain during an insert. In search mode delta is
  // the remaining delay; in displace mode it is the pushed-out entry's delta.
  typedef struct packed {
    logic               vld;
    logic               disp;
    logic [DELTA_W-1:0] delta;
    logic [SEQ_W-1:0]   seq;
    logic [PORT_W-1:0]  port;
  } dltq_carry_t;

  // Commands broadcast from the controller to the cells.
  typedef struct packed {
    logic dec;
    logic shift;
  } dltq_cmd_t;

endpackage : dltq_pkg

`default_nettype wire

### hdl/delta_list_timer_queue.sv
// Top level of the delta-list timer queue: controller plus a chain of cells.
//
// The slave channel takes one word per command. tuser selects the command:
// a one millisecond tick, or the insert of a new timer whose delay, sequence
// number and reply port travel in tdata. The master channel returns result
// words: an accepted or full answer for every insert, and one expired word
// per timer that fires on a tick, with tlast on the final word of each run.
// A tick that expires nothing returns no word at all.
//
// Timers live in a row of DEPTH cells, head first, each holding its delay
// relative to the cell before it. An insert enters cell 0 and moves one cell
// per cycle, subtracting deltas until it settles; displaced entries ripple
// right behind it. The answer is registered at acceptance, and the input
// stays closed until the walk has passed every live cell. A tick decrements
// the head at acceptance, then, while the receiver takes each word, removes
// one expired timer per cycle by shifting the whole chain left, at most 16
// timers per tick. If the receiver stalls, the result register holds
// its word and the queue waits. Reset empties the queue and the result
// register.

`timescale 1ns / 1ps
`default_nettype none

module delta_list_timer_queue
  import dltq_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [79:0] s_axis_tdata_i,  // delay_ms[30:0], seq_num[62:31], port_num[78:63]
  input  wire logic        s_axis_tuser_i,  // func
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [55:0]      m_axis_tdata_o,  // kind[1:0], exp_seq[33:2], exp_port[49:34]
  output logic             m_axis_tlast_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_EXP
  } state_e;

  state_e             state_q;
  logic [CntW-1:0]    count_q;
  logic [CntW-1:0]    wait_q;
  logic [NRES_W-1:0]  nres_q;
  logic               ins_vld_q;
  dltq_carry_t        ins_q;
  logic               out_vld_q;
  logic [KIND_W-1:0]  out_kind_q;
  logic [SEQ_W-1:0]   out_seq_q;
  logic [PORT_W-1:0]  out_port_q;
  logic               out_last_q;

  // Chain wiring; the extra slot at the right end reads as an empty cell.
  dltq_entry_t ent   [0:DEPTH];
  dltq_carry_t carry [0:DEPTH];
  dltq_cmd_t   cmd;

  logic [DELTA_W-1:0] in_delay;
  logic [SEQ_W-1:0]   in_seq;
  logic [PORT_W-1:0]  in_port;
  logic               out_free;
  logic               in_acc;
  logic               is_ins;
  logic               full;
  logic               head_zero;
  logic               next_zero;
  logic               emit;
  logic               exp_last;

  assign in_delay = s_axis_tdata_i[30:0];
  assign in_seq   = s_axis_tdata_i[62:31];
  assign in_port  = s_axis_tdata_i[78:63];

  assign out_free        = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = (state_q == ST_IDLE) && out_free;
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_ins          = (s_axis_tuser_i == FUNC_INSERT);
  assign full            = (count_q == CntW'(DEPTH));

  // The head expires when its delta reached zero; the run ends at the
  // result cap or when the entry behind it is empty or still has time left.
  assign head_zero = ent[0].vld && (ent[0].delta == '0);
  assign next_zero = ent[1].vld && (ent[1].delta == '0);
  assign emit      = (state_q == ST_EXP) && head_zero &&
                     (nres_q < NRES_W'(MAX_RESULTS)) && out_free;
  assign exp_last  = (nres_q == NRES_W'(MAX_RESULTS - 1)) || !next_zero;

  assign cmd.shift = emit;
  assign cmd.dec   = in_acc && !is_ins;

  always_comb begin
    carry[0]     = ins_q;
    carry[0].vld = ins_vld_q;
  end

  assign ent[DEPTH] = '0;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    dltq_cmd_t cell_cmd;

    // Only the head cell counts down on a tick.
    assign cell_cmd.shift = cmd.shift;
    assign cell_cmd.dec   = (g == 0) ? cmd.dec : 1'b0;

    dltq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .cmd_i   (cell_cmd),
      .carry_i (carry[g]),
      .right_i (ent[g+1]),
      .carry_o (carry[g+1]),
      .ent_o   (ent[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      count_q    <= '0;
      wait_q     <= '0;
      nres_q     <= '0;
      ins_vld_q  <= 1'b0;
      ins_q      <= '0;
      out_vld_q  <= 1'b0;
      out_kind_q <= KIND_ACCEPTED;
      out_seq_q  <= '0;
      out_port_q <= '0;
      out_last_q <= 1'b0;
    end else begin
      ins_vld_q <= 1'b0;
      if (out_vld_q && m_axis_tready_i) begin
        out_vld_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (is_ins) begin
              out_vld_q  <= 1'b1;
              out_kind_q <= full ? KIND_FULL : KIND_ACCEPTED;
              out_seq_q  <= '0;
              out_port_q <= '0;
              out_last_q <= 1'b1;
              if (!full) begin
                ins_vld_q     <= 1'b1;
                ins_q.disp    <= 1'b0;
                ins_q.delta   <= in_delay;
                ins_q.seq     <= in_seq;
                ins_q.port    <= in_port;
                count_q       <= count_q + CntW'(1);
                wait_q        <= count_q + CntW'(1);
                state_q       <= ST_WALK;
              end
            end else begin
              nres_q <= '0;
              if (count_q != '0) begin
                state_q <= ST_EXP;
              end
            end
          end
        end
        ST_WALK: begin
          // The insert settles by the time it has passed every live cell.
          wait_q <= wait_q - CntW'(1);
          if (wait_q == CntW'(1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_EXP: begin
          if (!head_zero) begin
            state_q <= ST_IDLE;
          end else if (emit) begin
            out_vld_q  <= 1'b1;
            out_kind_q <= KIND_EXPIRED;
            out_seq_q  <= ent[0].seq;
            out_port_q <= ent[0].port;
            out_last_q <= exp_last;
            nres_q     <= nres_q + NRES_W'(1);
            count_q    <= count_q - CntW'(1);
            if (exp_last) begin
              state_q <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tdata_o  = {6'd0, out_port_q, out_seq_q, out_kind_q};

endmodule : delta_list_timer_queue

`default_nettype wire

### hdl/dltq_cell.sv
// One cell of the timer chain: holds a single entry and passes an insert on.
`timescale 1ns / 1ps
`default_nettype none

module dltq_cell
  import dltq_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire dltq_cmd_t   cmd_i,
  input  wire dltq_carry_t carry_i,
  input  wire dltq_entry_t right_i,
  output dltq_carry_t      carry_o,
  output dltq_entry_t      ent_o
);

  logic               vld_q, vld_d;
  logic [DELTA_W-1:0] delta_q, delta_d;
  logic [SEQ_W-1:0]   seq_q, seq_d;
  logic [PORT_W-1:0]  port_q, port_d;
  logic               cvld_q, cvld_d;
  dltq_carry_t        cpay_q, cpay_d;

  always_comb begin
    vld_d   = vld_q;
    delta_d = delta_q;
    seq_d   = seq_q;
    port_d  = port_q;
    cvld_d  = 1'b0;
    cpay_d  = carry_i;
    if (cmd_i.shift) begin
      vld_d   = right_i.vld;
      delta_d = right_i.delta;
      seq_d   = right_i.seq;
      port_d  = right_i.port;
    end else if (cmd_i.dec) begin
      if (vld_q && (delta_q != '0)) begin
        delta_d = delta_q - DELTA_W'(1);
      end
    end else if (carry_i.vld) begin
      if (!carry_i.disp && vld_q && (carry_i.delta > delta_q)) begin
        // Pass this entry and keep searching with what is left.
        cvld_d       = 1'b1;
        cpay_d.delta = carry_i.delta - delta_q;
      end else begin
        // Take the carried timer here; push the old one to the right.
        vld_d   = 1'b1;
        delta_d = carry_i.delta;
        seq_d   = carry_i.seq;
        port_d  = carry_i.port;
        if (vld_q) begin
          cvld_d       = 1'b1;
          cpay_d.disp  = 1'b1;
          cpay_d.delta = carry_i.disp ? delta_q : (delta_q - carry_i.delta);
          cpay_d.seq   = seq_q;
          cpay_d.port  = port_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= 1'b0;
      cvld_q <= 1'b0;
    end else begin
      vld_q  <= vld_d;
      cvld_q <= cvld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    delta_q <= delta_d;
    seq_q   <= seq_d;
    port_q  <= port_d;
    cpay_q  <= cpay_d;
  end

  always_comb begin
    carry_o     = cpay_q;
    carry_o.vld = cvld_q;
    ent_o.vld   = vld_q;
    ent_o.delta = delta_q;
    ent_o.seq   = seq_q;
    ent_o.port  = port_q;
  end

endmodule : dltq_cell

`default_nettype wire

### tb/sv/tb.sv
// Self-checking testbench for the delta-list timer queue.
`timescale 1ns / 1ps

module tb;
  import dltq_pkg::*;

  localparam int unsigned QDEPTH      = 16;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam logic [DELTA_W-1:0] DELAY_MAX = 31'h7FFF_FFFF;

  // One result word, unpacked into its fields.
  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [SEQ_W-1:0]  seq;
    logic [PORT_W-1:0] port;
    logic              last;
  } timer_result_t;

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [79:0] s_axis_tdata_i  = '0;  // delay_ms[30:0], seq_num[62:31], port_num[78:63]
  logic        s_axis_tuser_i  = 1'b0;  // func
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [55:0] m_axis_tdata_o;  // kind[1:0], exp_seq[33:2], exp_port[49:34]
  logic        m_axis_tlast_o;

  // Shadow copy of the timer list, advanced at every accepted command word.
  logic [DELTA_W-1:0] shadow_delta [QDEPTH];
  logic [SEQ_W-1:0]   shadow_seq   [QDEPTH];
  logic [PORT_W-1:0]  shadow_port  [QDEPTH];
  int unsigned        shadow_count = 0;

  // Result words the queue still owes us, oldest first.
  timer_result_t due_result_words [$];

  int tx_idle_pct  = 0;
  int rx_idle_pct  = 0;
  int rx_hold_req  = 0;
  int rx_hold_left = 0;
  int big_delays_left = 3;

  int unsigned cycle_count    = 0;
  int unsigned words_sent     = 0;
  int unsigned words_checked  = 0;
  int unsigned expiries_seen  = 0;
  int unsigned rejects_seen   = 0;
  int unsigned mismatch_count = 0;

  timer_result_t got_word;
  timer_result_t want_word;

  delta_list_timer_queue #(
    .DEPTH(QDEPTH)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always #10 clk_i = ~clk_i;

  // Hard stop in case the queue hangs or a word goes missing.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: cycle limit reached with %0d result words outstanding", $time,
               due_result_words.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // Receiver side. A hold request closes the output until its count runs
  // out; otherwise tready follows the current idle rate.
  always @(posedge clk_i) begin
    if (rx_hold_req != 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req  = 0;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      m_axis_tready_i <= 1'b0;
    end else begin
      m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  task automatic report_mismatch(input string field, input longint unsigned want,
                                 input longint unsigned got);
    $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    mismatch_count++;
  endtask

  // Every accepted result word is compared with the oldest one owed.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_word.kind = m_axis_tdata_o[1:0];
      got_word.seq  = m_axis_tdata_o[33:2];
      got_word.port = m_axis_tdata_o[49:34];
      got_word.last = m_axis_tlast_o;
      if (due_result_words.size() == 0) begin
        $display("%0t: result word with nothing owed, kind %0d seq 0x%0h port 0x%0h",
                 $time, got_word.kind, got_word.seq, got_word.port);
        mismatch_count++;
      end else begin
        want_word = due_result_words.pop_front();
        if (got_word.kind !== want_word.kind) report_mismatch("kind", want_word.kind, got_word.kind);
        if (got_word.seq !== want_word.seq) report_mismatch("exp_seq", want_word.seq, got_word.seq);
        if (got_word.port !== want_word.port)
          report_mismatch("exp_port", want_word.port, got_word.port);
        if (got_word.last !== want_word.last)
          report_mismatch("tlast", want_word.last, got_word.last);
      end
      words_checked++;
      if (got_word.kind == KIND_EXPIRED) expiries_seen++;
      if (got_word.kind == KIND_FULL) rejects_seen++;
    end
  end

  function automatic void owe_word(input logic [KIND_W-1:0] kind, input logic [SEQ_W-1:0] seq,
                                   input logic [PORT_W-1:0] port, input logic last);
    timer_result_t w;
    w.kind = kind;
    w.seq  = seq;
    w.port = port;
    w.last = last;
    due_result_words.push_back(w);
  endfunction

  // Applies one command to the shadow list and records the words it owes.
  function automatic void queue_shadow_step(input logic func, input logic [DELTA_W-1:0] dly,
                                            input logic [SEQ_W-1:0] seq,
                                            input logic [PORT_W-1:0] port);
    logic [DELTA_W-1:0] remaining;
    logic [SEQ_W-1:0]   head_seq;
    logic [PORT_W-1:0]  head_port;
    int unsigned        slot;
    int unsigned        fired;
    int unsigned        i;
    remaining = dly;
    slot      = shadow_count;
    fired     = 0;
    if (func == FUNC_INSERT) begin
      if (shadow_count >= QDEPTH) begin
        owe_word(KIND_FULL, '0, '0, 1'b1);
      end else begin
        // Walk the deltas; settle ahead of the first entry that is not shorter.
        for (i = 0; i < shadow_count; i++) begin
          if (remaining > shadow_delta[i]) begin
            remaining -= shadow_delta[i];
          end else begin
            shadow_delta[i] -= remaining;
            slot = i;
            break;
          end
        end
        for (i = shadow_count; i > slot; i--) begin
          shadow_delta[i] = shadow_delta[i-1];
          shadow_seq[i]   = shadow_seq[i-1];
          shadow_port[i]  = shadow_port[i-1];
        end
        shadow_delta[slot] = remaining;
        shadow_seq[slot]   = seq;
        shadow_port[slot]  = port;
        shadow_count++;
        owe_word(KIND_ACCEPTED, '0, '0, 1'b1);
      end
    end else if (shadow_count != 0) begin
      if (shadow_delta[0] != 0) shadow_delta[0]--;
      while (shadow_count > 0 && shadow_delta[0] == 0 && fired < MAX_RESULTS) begin
        head_seq  = shadow_seq[0];
        head_port = shadow_port[0];
        for (i = 1; i < shadow_count; i++) begin
          shadow_delta[i-1] = shadow_delta[i];
          shadow_seq[i-1]   = shadow_seq[i];
          shadow_port[i-1]  = shadow_port[i];
        end
        shadow_count--;
        fired++;
        // The run ends when the new head is not due or the cap is reached.
        owe_word(KIND_EXPIRED, head_seq, head_port,
                 !(shadow_count > 0 && shadow_delta[0] == 0 && fired < MAX_RESULTS));
      end
    end
  endfunction

  // Offers one command word and returns once the queue has taken it.
  task automatic send_word(input logic func, input logic [DELTA_W-1:0] dly,
                           input logic [SEQ_W-1:0] seq, input logic [PORT_W-1:0] port);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= func;
    s_axis_tdata_i  <= {1'b0, port, seq, dly};
    do @(posedge clk_i); while (!s_axis_tready_o);
    queue_shadow_step(func, dly, seq, port);
    words_sent++;
  endtask

  task automatic send_tick();
    send_word(FUNC_TICK, DELTA_W'($urandom()), $urandom(), PORT_W'($urandom()));
  endtask

  task automatic send_insert(input logic [DELTA_W-1:0] dly);
    send_word(FUNC_INSERT, dly, $urandom(), PORT_W'($urandom()));
  endtask

  // Closes the input, waits for every owed word, then lets a possible
  // silent tick or insert walk finish.
  task automatic wait_until_drained();
    s_axis_tvalid_i <= 1'b0;
    while (due_result_words.size() != 0) @(posedge clk_i);
    repeat (QDEPTH + 4) @(posedge clk_i);
  endtask

  // Mostly short delays so that timers keep expiring; a handful of huge
  // ones stay in the list for good and exercise the upper delay bits.
  task automatic send_random_word();
    int unsigned        pick;
    logic [DELTA_W-1:0] dly;
    pick = $urandom_range(0, 99);
    if (pick < ((shadow_count >= QDEPTH - 2) ? 20 : 45)) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        dly = DELTA_W'($urandom_range(0, 6));
      end else if (pick < 95 || big_delays_left == 0) begin
        dly = DELTA_W'($urandom_range(0, 60));
      end else begin
        dly = DELTA_W'($urandom());
        big_delays_left--;
      end
      send_insert(dly);
    end else begin
      send_tick();
    end
  endtask

  task automatic test_empty_tick();
    send_tick();
    wait_until_drained();
  endtask

  task automatic test_zero_delay();
    send_word(FUNC_INSERT, '0, '0, '0);
    send_word(FUNC_TICK, '0, '0, '0);
    wait_until_drained();
  endtask

  // Two timers with the same deadline: the later insert must fire first.
  // The first tick expires nothing.
  task automatic test_same_deadline();
    send_word(FUNC_INSERT, 31'd2, 32'hFFFF_FFFF, 16'hFFFF);
    send_word(FUNC_INSERT, 31'd2, 32'h0000_0001, 16'h0001);
    send_tick();
    send_tick();
    wait_until_drained();
  endtask

  // Sixteen timers due together, one insert too many, then one tick that
  // must return the whole run with tlast on the final word only.
  task automatic test_long_expiry_run();
    for (int i = 0; i < QDEPTH; i++) send_insert(31'd1);
    send_insert(31'd1);
    send_tick();
    wait_until_drained();
  endtask

  // The output stays closed for a long stretch while commands keep coming,
  // so the result register fills and the input has to stall.
  task automatic test_output_stall();
    rx_hold_req = 300;
    for (int i = 0; i < 40; i++) begin
      if (i % 2 == 0) send_insert(DELTA_W'($urandom_range(0, 2)));
      else send_tick();
    end
    wait_until_drained();
  endtask

  task automatic test_random_traffic(input int tx_pct, input int rx_pct, input int count);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < count; i++) send_random_word();
    wait_until_drained();
  endtask

  // Fill the list with huge delays, including the largest one, then try
  // two more inserts and a tick against the full list.
  task automatic test_full_queue();
    send_insert(DELAY_MAX);
    while (shadow_count < QDEPTH) send_insert({1'b1, 30'($urandom())});
    send_insert(DELAY_MAX);
    send_insert('0);
    send_tick();
    wait_until_drained();
  endtask

  initial begin
    tx_idle_pct = 21;
    rx_idle_pct = 58;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_tick();
    test_zero_delay();
    test_same_deadline();
    test_long_expiry_run();
    test_output_stall();
    test_random_traffic(21, 58, 60);
    test_random_traffic(58, 21, 60);
    test_random_traffic(0, 0, 60);
    test_full_queue();

    $display("Sent %0d command words and checked %0d result words (%0d expiries, %0d rejects).",
             words_sent, words_checked, expiries_seen, rejects_seen);
    $display("Covered empty ticks, same-deadline order, a full expiry run, a long output stall,");
    $display("random traffic under three idle mixes and inserts against a full list.");
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
